// ===== hdl/aimr_pkg.sv =====
// Shared types and constants of the affine inverse-map resampler.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package aimr_pkg;

    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DEF_CHANNELS  = 3;
    localparam int DEF_FRAC_BITS = 16;

    localparam int COEF_W    = 32;
    localparam int SIZE_W    = 9;
    localparam int DIM_W     = 11;
    localparam int PROD_W    = COEF_W + DIM_W + 1;
    localparam int T_W       = PROD_W + 1;
    localparam int PIX_W     = 8;
    localparam int MAX_CH    = 3;
    localparam int REG_IDX_W = 3;
    localparam int EXT_W     = DIM_W + 1;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BILIN = 2'd1;
    localparam logic [1:0] MODE_NEAR  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_XX   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_XY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_XT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_YX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_YY   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_YT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLS = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROWS = 3'd7;

    typedef struct packed {
        logic                      valid;
        logic [1:0]                mode;
        logic [DIM_W-1:0]          col;
        logic [DIM_W-1:0]          row;
        logic [MAX_CH*PIX_W-1:0]   pix;
    } t_item;

    typedef struct packed {
        logic [COEF_W-1:0] xx;
        logic [COEF_W-1:0] xy;
        logic [COEF_W-1:0] xt;
        logic [COEF_W-1:0] yx;
        logic [COEF_W-1:0] yy;
        logic [COEF_W-1:0] yt;
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic in_src;
    } t_smp;

endpackage

// ===== hdl/aimr_map.sv =====
// Affine mapping of the destination point: products, then the two sums.
// Depends on aimr_pkg.
`timescale 1ns / 1ps

module aimr_map
    import aimr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_item               i_item,
    input  t_cfg                i_cfg,
    output t_item               o_item,
    output logic signed [T_W-1:0] o_tx,
    output logic signed [T_W-1:0] o_ty
);

    t_item                      r_item1, r_item2;
    logic signed [PROD_W-1:0]   r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [T_W-1:0]      r_tx, r_ty;
    logic signed [DIM_W:0]      col_s, row_s;

    assign col_s = $signed({1'b0, i_item.col});
    assign row_s = $signed({1'b0, i_item.row});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item1.valid <= 1'b0;
            r_item2.valid <= 1'b0;
        end else if (i_en) begin
            r_item1.valid <= i_item.valid;
            r_item2.valid <= r_item1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1.mode <= i_item.mode;
            r_item1.col  <= i_item.col;
            r_item1.row  <= i_item.row;
            r_item1.pix  <= i_item.pix;
            r_pxx <= PROD_W'($signed(i_cfg.xx) * col_s);
            r_pxy <= PROD_W'($signed(i_cfg.xy) * row_s);
            r_pyx <= PROD_W'($signed(i_cfg.yx) * col_s);
            r_pyy <= PROD_W'($signed(i_cfg.yy) * row_s);

            r_item2.mode <= r_item1.mode;
            r_item2.col  <= r_item1.col;
            r_item2.row  <= r_item1.row;
            r_item2.pix  <= r_item1.pix;
            r_tx <= T_W'(r_pxx) + T_W'(r_pxy) + T_W'($signed(i_cfg.xt));
            r_ty <= T_W'(r_pyx) + T_W'(r_pyy) + T_W'($signed(i_cfg.yt));
        end
    end

    assign o_item = r_item2;
    assign o_tx   = r_tx;
    assign o_ty   = r_ty;

endmodule

// ===== hdl/aimr_fetch.sv =====
// Bounds check, neighbour addressing, four parity banks of the source image
// and bilinear weights. Depends on aimr_pkg.
`timescale 1ns / 1ps

module aimr_fetch
    import aimr_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  t_item                        i_item,
    input  logic signed [T_W-1:0]        i_tx,
    input  logic signed [T_W-1:0]        i_ty,
    input  t_cfg                         i_cfg,
    output t_smp                         o_smp,
    output logic [CHANNELS*PIX_W-1:0]    o_pix [4],
    output logic [2*FRAC_BITS:0]         o_w [4]
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int HC   = (MAX_COLS + 1) / 2;
    localparam int HR   = (MAX_ROWS + 1) / 2;
    localparam int HCW  = (HC > 1) ? $clog2(HC) : 1;
    localparam int HRW  = (HR > 1) ? $clog2(HR) : 1;
    localparam int DEPTH = HR * HC;
    localparam int BAW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW   = CHANNELS * PIX_W;
    localparam int WW   = 2 * FRAC_BITS + 1;
    localparam int FW   = FRAC_BITS + 1;

    logic [EXT_W-1:0]     cols_e, rows_e, cols_m1, rows_m1;
    logic signed [T_W-1:0] xmax, ymax, xr, yr;
    logic                 in_src, l1ok, k1ok, is_smp, we;
    logic [CW-1:0]        l;
    logic [RW-1:0]        k;
    logic [CW:0]          xn;
    logic [RW:0]          yn;
    logic [FRAC_BITS-1:0] a, b;
    logic [FW-1:0]        oma, omb;
    logic [HCW-1:0]       cadd [2];
    logic [HRW-1:0]       radd [2];
    logic [BAW-1:0]       raddr [4];
    logic [BAW-1:0]       waddr;
    logic [1:0]           wbank;

    t_smp                 r_smp;
    logic                 r_l0, r_k0, r_l1ok, r_k1ok;
    logic [PW-1:0]        r_rd [4];
    logic [WW-1:0]        r_w [4];

    always_comb begin
        cols_e = EXT_W'(i_cfg.cols);
        if (cols_e == '0) cols_e = EXT_W'(1);
        if (cols_e > EXT_W'(MAX_COLS)) cols_e = EXT_W'(MAX_COLS);
        rows_e = EXT_W'(i_cfg.rows);
        if (rows_e == '0) rows_e = EXT_W'(1);
        if (rows_e > EXT_W'(MAX_ROWS)) rows_e = EXT_W'(MAX_ROWS);
        cols_m1 = cols_e - EXT_W'(1);
        rows_m1 = rows_e - EXT_W'(1);
        xmax = $signed(T_W'(cols_m1) << FRAC_BITS);
        ymax = $signed(T_W'(rows_m1) << FRAC_BITS);
        in_src = (i_tx >= 0) && (i_ty >= 0) && (i_tx <= xmax) && (i_ty <= ymax);

        // nearest: round half up, clamp to the last column and row, zero fraction
        xr = i_tx + $signed(T_W'(1) << (FRAC_BITS - 1));
        yr = i_ty + $signed(T_W'(1) << (FRAC_BITS - 1));
        xn = xr[FRAC_BITS +: CW+1];
        yn = yr[FRAC_BITS +: RW+1];
        if (i_item.mode == MODE_NEAR) begin
            l = (EXT_W'(xn) > cols_m1) ? CW'(cols_m1) : CW'(xn);
            k = (EXT_W'(yn) > rows_m1) ? RW'(rows_m1) : RW'(yn);
            a = '0;
            b = '0;
        end else begin
            l = i_tx[FRAC_BITS +: CW];
            k = i_ty[FRAC_BITS +: RW];
            a = i_tx[FRAC_BITS-1:0];
            b = i_ty[FRAC_BITS-1:0];
        end
        // keep a far neighbour only when it lies in the image and has a weight
        l1ok = ((EXT_W'(l) + EXT_W'(1)) < cols_e) && (a != '0);
        k1ok = ((EXT_W'(k) + EXT_W'(1)) < rows_e) && (b != '0);
        oma  = (FW'(1) << FRAC_BITS) - FW'(a);
        omb  = (FW'(1) << FRAC_BITS) - FW'(b);

        // each parity bank holds exactly one of the four neighbours
        for (int p = 0; p < 2; p++) begin
            cadd[p] = HCW'(((CW+1)'(l) + (CW+1)'(l[0] != p[0])) >> 1);
            radd[p] = HRW'(((RW+1)'(k) + (RW+1)'(k[0] != p[0])) >> 1);
        end
        for (int bk = 0; bk < 4; bk++) begin
            raddr[bk] = BAW'(radd[bk/2]) * BAW'(HC) + BAW'(cadd[bk%2]);
        end

        is_smp = i_item.valid &&
                 (i_item.mode == MODE_BILIN || i_item.mode == MODE_NEAR);
        we = i_item.valid && (i_item.mode == MODE_LOAD) &&
             (EXT_W'(i_item.col) < EXT_W'(MAX_COLS)) &&
             (EXT_W'(i_item.row) < EXT_W'(MAX_ROWS));
        waddr = BAW'(HRW'(i_item.row >> 1)) * BAW'(HC) + BAW'(HCW'(i_item.col >> 1));
        wbank = {i_item.row[0], i_item.col[0]};
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [PW-1:0] mem [DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (we && wbank == 2'(g)) mem[waddr] <= i_item.pix[PW-1:0];
                r_rd[g] <= mem[raddr[g]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp.valid <= 1'b0;
        end else if (i_en) begin
            r_smp.valid <= is_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_smp.in_src <= in_src;
            r_l0   <= l[0];
            r_k0   <= k[0];
            r_l1ok <= l1ok;
            r_k1ok <= k1ok;
            r_w[0] <= WW'(oma * omb);
            r_w[1] <= WW'(FW'(a) * omb);
            r_w[2] <= WW'(oma * FW'(b));
            r_w[3] <= WW'(FW'(a) * FW'(b));
        end
    end

    // route banks to neighbour order; drop a neighbour whose weight is zero
    always_comb begin
        o_pix[0] = r_rd[{r_k0, r_l0}];
        o_pix[1] = r_l1ok ? r_rd[{r_k0, ~r_l0}] : '0;
        o_pix[2] = r_k1ok ? r_rd[{~r_k0, r_l0}] : '0;
        o_pix[3] = (r_l1ok && r_k1ok) ? r_rd[{~r_k0, ~r_l0}] : '0;
    end

    assign o_w   = r_w;
    assign o_smp = r_smp;

endmodule

// ===== hdl/aimr_lane.sv =====
// One channel lane: four weighted taps, then their sum.
// Depends on aimr_pkg.
`timescale 1ns / 1ps

module aimr_lane
    import aimr_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [PIX_W-1:0]              i_pix [4],
    input  logic [2*FRAC_BITS:0]          i_w [4],
    output logic [2*FRAC_BITS+PIX_W+2:0]  o_sum
);

    localparam int WW = 2 * FRAC_BITS + 1;
    localparam int MW = WW + PIX_W;
    localparam int SW = MW + 2;

    logic [MW-1:0] r_prod [4];
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= MW'(i_w[j] * i_pix[j]);
            end
            r_sum <= SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + SW'(r_prod[3]);
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/affine_inverse_map_resampler_core.sv =====
// Top level of the affine inverse-map resampler: configuration registers,
// mapping, fetch, channel lanes and the merging output stage.
// Depends on aimr_pkg, aimr_map, aimr_fetch, aimr_lane.
//
// Usage: configure the 2x3 matrix (signed Q16.16) and the source size through
// the write port while the block is idle. Load the source with mode 0 requests
// (col, row, channels); each sample request (mode 1 bilinear, mode 2 nearest)
// names a destination point and gives one result; mode 3 gives nothing.
// Results carry three 8-bit channels in m_axis_tdata and the inside flag in
// m_axis_tuser; a point outside the source gives zeros with inside cleared.
// Pipeline: two map stages, one bank read, two lane stages and the output
// register (the merge is combinational). Throughput: one request per clock
// while m_axis does not stall; the four neighbours come from four row/column parity
// banks, one read each.
// A stall on m_axis freezes the whole pipe and drops s_axis_tready.
// Reset restores identity matrix and 256x256 size and empties the pipe; the
// image memory is not cleared and must be loaded before it is sampled.
`timescale 1ns / 1ps

module affine_inverse_map_resampler_core
    import aimr_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COEF_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // col[10:0], row[21:11], in_ch0[29:22], in_ch1[37:30], in_ch2[45:38], zero pad
    input  logic [47:0]            s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_ch0[7:0], out_ch1[15:8], out_ch2[23:16]
    output logic [23:0]            m_axis_tdata,
    // inside_res[0]
    output logic                   m_axis_tuser
);

    localparam int WW = 2 * FRAC_BITS + 1;
    localparam int SW = WW + PIX_W + 2;
    localparam int PW = CHANNELS * PIX_W;

    t_cfg                  r_cfg;
    t_item                 in_item, map_item;
    logic signed [T_W-1:0] tx, ty;
    t_smp                  f_smp, r_smp_a, r_smp_b;
    logic [PW-1:0]         f_pix [4];
    logic [WW-1:0]         f_w [4];
    logic [SW-1:0]         lane_sum [MAX_CH];
    logic [SW-1:0]         rnd [MAX_CH];
    logic [MAX_CH*PIX_W-1:0] merged;
    logic                  en;
    logic                  r_ovalid, r_inside;
    logic [23:0]           r_odata;

    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xx   <= COEF_W'(1) << FRAC_BITS;
            r_cfg.xy   <= '0;
            r_cfg.xt   <= '0;
            r_cfg.yx   <= '0;
            r_cfg.yy   <= COEF_W'(1) << FRAC_BITS;
            r_cfg.yt   <= '0;
            r_cfg.cols <= SIZE_W'(256);
            r_cfg.rows <= SIZE_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_XX:   r_cfg.xx   <= i_cfg_data;
                REG_XY:   r_cfg.xy   <= i_cfg_data;
                REG_XT:   r_cfg.xt   <= i_cfg_data;
                REG_YX:   r_cfg.yx   <= i_cfg_data;
                REG_YY:   r_cfg.yy   <= i_cfg_data;
                REG_YT:   r_cfg.yt   <= i_cfg_data;
                REG_COLS: r_cfg.cols <= i_cfg_data[SIZE_W-1:0];
                REG_ROWS: r_cfg.rows <= i_cfg_data[SIZE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        in_item.valid = s_axis_tvalid && en;
        in_item.mode  = s_axis_tuser;
        in_item.col   = s_axis_tdata[10:0];
        in_item.row   = s_axis_tdata[21:11];
        in_item.pix   = s_axis_tdata[45:22];
    end

    aimr_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (in_item),
        .i_cfg   (r_cfg),
        .o_item  (map_item),
        .o_tx    (tx),
        .o_ty    (ty)
    );

    aimr_fetch #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (map_item),
        .i_tx    (tx),
        .i_ty    (ty),
        .i_cfg   (r_cfg),
        .o_smp   (f_smp),
        .o_pix   (f_pix),
        .o_w     (f_w)
    );

    for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            logic [PIX_W-1:0] lpix [4];
            always_comb begin
                for (int j = 0; j < 4; j++) lpix[j] = f_pix[j][c*PIX_W +: PIX_W];
            end
            aimr_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk (i_clk),
                .i_en  (en),
                .i_pix (lpix),
                .i_w   (f_w),
                .o_sum (lane_sum[c])
            );
        end else begin : g_off
            assign lane_sum[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_a.valid <= 1'b0;
            r_smp_b.valid <= 1'b0;
            r_ovalid      <= 1'b0;
        end else if (en) begin
            r_smp_a.valid <= f_smp.valid;
            r_smp_b.valid <= r_smp_a.valid;
            r_ovalid      <= r_smp_b.valid;
        end
    end

    // merge: round half up, saturate, zero when outside
    always_comb begin
        for (int c = 0; c < MAX_CH; c++) begin
            rnd[c] = lane_sum[c] + (SW'(1) << (2 * FRAC_BITS - 1));
            if ((rnd[c] >> (2 * FRAC_BITS)) > SW'(255)) begin
                merged[c*PIX_W +: PIX_W] = 8'hFF;
            end else begin
                merged[c*PIX_W +: PIX_W] = PIX_W'(rnd[c] >> (2 * FRAC_BITS));
            end
            if (!r_smp_b.in_src) merged[c*PIX_W +: PIX_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp_a.in_src <= f_smp.in_src;
            r_smp_b.in_src <= r_smp_a.in_src;
            r_odata        <= merged;
            r_inside       <= r_smp_b.in_src;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_inside;

endmodule

// ===== tb/sv/resample_checker.sv =====
// Checker for the affine inverse-map resampler: watches the write port and both streams.
// Predicts every sample result and compares it with the block output.
// Depends on aimr_pkg.
`timescale 1ns / 1ps

module resample_checker
    import aimr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [23:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       in_src;
    } t_pixel_out;

    logic [23:0]       src_img [0:DEF_MAX_COLS*DEF_MAX_ROWS-1];
    logic [COEF_W-1:0] coef [0:5];
    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    t_pixel_out        expected_pixels [$];

    function automatic int eff_dim(logic [SIZE_W-1:0] v, int lim);
        int s;
        s = int'(v);
        if (s == 0) s = 1;
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic logic [23:0] src_at(int r, int c);
        return src_img[r * DEF_MAX_COLS + c];
    endfunction

    function automatic t_pixel_out resample_pixel(logic [1:0] mode, int col, int row);
        t_pixel_out res;
        longint tx, ty, xmax, ymax, a, b, w00, w01, w10, w11, acc;
        int cw, rh, l, k, l1, k1, x, y;
        logic [23:0] p00, p01, p10, p11;
        logic [2:0][7:0] chans;
        res = '0;
        chans = '0;
        cw = eff_dim(cols_reg, DEF_MAX_COLS);
        rh = eff_dim(rows_reg, DEF_MAX_ROWS);
        tx = longint'($signed(coef[0])) * col + longint'($signed(coef[1])) * row
             + longint'($signed(coef[2]));
        ty = longint'($signed(coef[3])) * col + longint'($signed(coef[4])) * row
             + longint'($signed(coef[5]));
        xmax = longint'(cw - 1) << 16;
        ymax = longint'(rh - 1) << 16;
        if (tx < 0 || ty < 0 || tx > xmax || ty > ymax) return res;
        res.in_src = 1'b1;
        if (mode == MODE_BILIN) begin
            l = int'(tx >>> 16);
            k = int'(ty >>> 16);
            a = tx & 64'hFFFF;
            b = ty & 64'hFFFF;
            l1 = (l + 1 < cw) ? l + 1 : cw - 1;
            k1 = (k + 1 < rh) ? k + 1 : rh - 1;
            w00 = (65536 - a) * (65536 - b);
            w01 = a * (65536 - b);
            w10 = (65536 - a) * b;
            w11 = a * b;
            p00 = src_at(k, l);
            p01 = src_at(k, l1);
            p10 = src_at(k1, l);
            p11 = src_at(k1, l1);
            for (int ch = 0; ch < 3; ch++) begin
                acc = w00 * p00[8*ch +: 8] + w01 * p01[8*ch +: 8]
                      + w10 * p10[8*ch +: 8] + w11 * p11[8*ch +: 8];
                acc = (acc + (64'sd1 <<< 31)) >>> 32;
                if (acc > 255) acc = 255;
                chans[ch] = acc[7:0];
            end
        end else begin
            // round half up, then clamp to the last column and row
            x = int'((tx + 32768) >>> 16);
            y = int'((ty + 32768) >>> 16);
            if (x > cw - 1) x = cw - 1;
            if (y > rh - 1) y = rh - 1;
            chans = src_at(y, x);
        end
        res.ch0 = chans[0];
        res.ch1 = chans[1];
        res.ch2 = chans[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_out want;
        logic [10:0] col, row;
        if (!i_rst_n) begin
            coef[0] = 32'h0001_0000;
            coef[1] = '0;
            coef[2] = '0;
            coef[3] = '0;
            coef[4] = 32'h0001_0000;
            coef[5] = '0;
            cols_reg = 9'd256;
            rows_reg = 9'd256;
            expected_pixels.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COLS: cols_reg = i_cfg_data[SIZE_W-1:0];
                    REG_ROWS: rows_reg = i_cfg_data[SIZE_W-1:0];
                    default:  coef[i_cfg_idx] = i_cfg_data;
                endcase
            end
            // check the result leaving this edge before adding new requests
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: data %h inside %b", m_axis_tdata, m_axis_tuser);
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== want.ch0) begin
                        $error("out_ch0: expected %0d actual %0d", want.ch0, m_axis_tdata[7:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[15:8] !== want.ch1) begin
                        $error("out_ch1: expected %0d actual %0d", want.ch1, m_axis_tdata[15:8]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[23:16] !== want.ch2) begin
                        $error("out_ch2: expected %0d actual %0d", want.ch2,
                               m_axis_tdata[23:16]);
                        o_fail_count++;
                    end
                    if (m_axis_tuser !== want.in_src) begin
                        $error("inside_res: expected %0d actual %0d", want.in_src,
                               m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                col = s_axis_tdata[10:0];
                row = s_axis_tdata[21:11];
                case (s_axis_tuser)
                    MODE_LOAD: begin
                        if (col < DEF_MAX_COLS && row < DEF_MAX_ROWS)
                            src_img[int'(row) * DEF_MAX_COLS + int'(col)] = s_axis_tdata[45:22];
                    end
                    MODE_BILIN, MODE_NEAR: begin
                        expected_pixels.push_back(resample_pixel(s_axis_tuser, col, row));
                    end
                    default: ;  // drop the unused mode
                endcase
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== tb/sv/affine_inverse_map_resampler_core_tb.sv =====
// Testbench top for the affine inverse-map resampler core: clock, reset, stimulus, verdict.
// Depends on aimr_pkg, affine_inverse_map_resampler_core and resample_checker.
`timescale 1ns / 1ps

module affine_inverse_map_resampler_core_tb;
    import aimr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int REGION = 16;
    localparam int STALL_LIMIT = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    int                   fail_count;
    int                   pending;

    bit                   calm = 1'b0;
    bit                   loaded [0:DEF_MAX_COLS*DEF_MAX_ROWS-1];
    logic [COEF_W-1:0]    cfg_shadow [0:7];
    int                   ready_left = 0;
    int                   quiet_cycles = 0;

    affine_inverse_map_resampler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    resample_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: alternate runs of ready and stall bursts, or stay ready when calm
    always @(posedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            ready_left <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
            ready_left <= $urandom_range(0, 40);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int dim_of(logic [COEF_W-1:0] v, int lim);
        int s;
        s = int'(v[SIZE_W-1:0]);
        if (s == 0) s = 1;
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic bit is_loaded(int r, int c);
        return loaded[r * DEF_MAX_COLS + c];
    endfunction

    // a sample is sent only when every pixel it reads has been written
    function automatic bit reads_loaded(logic [1:0] mode, int col, int row);
        longint tx, ty;
        int cw, rh, l, k, l1, k1, x, y;
        if (mode != MODE_BILIN && mode != MODE_NEAR) return 1'b1;
        cw = dim_of(cfg_shadow[REG_COLS], DEF_MAX_COLS);
        rh = dim_of(cfg_shadow[REG_ROWS], DEF_MAX_ROWS);
        tx = longint'($signed(cfg_shadow[REG_XX])) * col
             + longint'($signed(cfg_shadow[REG_XY])) * row + longint'($signed(cfg_shadow[REG_XT]));
        ty = longint'($signed(cfg_shadow[REG_YX])) * col
             + longint'($signed(cfg_shadow[REG_YY])) * row + longint'($signed(cfg_shadow[REG_YT]));
        if (tx < 0 || ty < 0 || tx > (longint'(cw - 1) << 16) || ty > (longint'(rh - 1) << 16))
            return 1'b1;
        if (mode == MODE_BILIN) begin
            l = int'(tx >>> 16);
            k = int'(ty >>> 16);
            l1 = (l + 1 < cw) ? l + 1 : cw - 1;
            k1 = (k + 1 < rh) ? k + 1 : rh - 1;
            return is_loaded(k, l) && is_loaded(k, l1) && is_loaded(k1, l) && is_loaded(k1, l1);
        end
        x = int'((tx + 32768) >>> 16);
        y = int'((ty + 32768) >>> 16);
        if (x > cw - 1) x = cw - 1;
        if (y > rh - 1) y = rh - 1;
        return is_loaded(y, x);
    endfunction

    task automatic send_request(logic [1:0] mode, int col, int row, logic [23:0] pix);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {2'b00, pix, row[10:0], col[10:0]};
        @(posedge i_clk iff s_axis_tready);
        if (mode == MODE_LOAD && col < DEF_MAX_COLS && row < DEF_MAX_ROWS)
            loaded[row * DEF_MAX_COLS + col] = 1'b1;
    endtask

    task automatic send_sample(logic [1:0] mode, int col, int row);
        send_request(mode, col, row, 24'($urandom));
    endtask

    // hold the stream until every result is back and loads have drained
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] xx, logic [31:0] xy, logic [31:0] xt,
                              logic [31:0] yx, logic [31:0] yy, logic [31:0] yt,
                              logic [31:0] cols, logic [31:0] rows);
        logic [31:0] vals [0:7];
        vals = '{xx, xy, xt, yx, yy, yt, cols, rows};
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= REG_IDX_W'(i);
            i_cfg_data <= vals[i];
            cfg_shadow[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coef(int span);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            default: return 32'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic logic [31:0] rand_size;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd256;
            3: return 32'd511;
            4: return 32'd2;
            default: return 32'($urandom_range(1, REGION));
        endcase
    endfunction

    task automatic random_sample;
        logic [1:0] mode;
        int col, row;
        for (int t = 0; t < 40; t++) begin
            mode = $urandom_range(0, 1) ? MODE_BILIN : MODE_NEAR;
            col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
            row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
            if (reads_loaded(mode, col, row)) begin
                send_sample(mode, col, row);
                return;
            end
        end
        send_request(MODE_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047), 24'($urandom));
    endtask

    initial begin
        int sel;
        cfg_shadow = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 256, 256};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the working region, with both channel extremes at the origin and its right neighbour
        for (int r = 0; r < REGION; r++)
            for (int c = 0; c < REGION; c++)
                send_request(MODE_LOAD, c, r, (r == 0 && c == 0) ? 24'hFFFFFF :
                             (r == 0 && c == 1) ? 24'h000000 : 24'($urandom));
        send_request(MODE_LOAD, 2047, 2047, 24'hFFFFFF);
        send_request(MODE_LOAD, 256, 0, 24'h123456);
        send_request(MODE_LOAD, 0, 256, 24'h654321);
        send_request(MODE_UNUSED, 2047, 2047, 24'hFFFFFF);

        set_config(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, REGION, REGION);
        send_sample(MODE_BILIN, 0, 0);
        send_sample(MODE_BILIN, 15, 15);
        send_sample(MODE_BILIN, 16, 0);
        send_sample(MODE_NEAR, 0, 16);
        send_sample(MODE_NEAR, 2047, 2047);
        send_sample(MODE_NEAR, 15, 15);

        // half-pixel shift: bilinear averages, nearest rounds up
        set_config(32'h0001_0000, 0, 32'h0000_8000, 0, 32'h0001_0000, 32'h0000_8000,
                   REGION, REGION);
        send_sample(MODE_BILIN, 0, 0);
        send_sample(MODE_NEAR, 0, 0);
        send_sample(MODE_NEAR, 15, 15);
        send_sample(MODE_BILIN, 14, 14);

        set_config(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                   REGION, REGION);
        send_sample(MODE_BILIN, 0, 0);
        send_sample(MODE_NEAR, 1, 0);
        send_sample(MODE_BILIN, 0, 1);

        // size zero counts as one pixel, oversize as the store maximum
        set_config(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
        send_sample(MODE_BILIN, 0, 0);
        send_sample(MODE_NEAR, 1, 0);
        set_config(32'h0000_4000, 0, 0, 0, 32'h0000_4000, 0, 511, 511);
        send_sample(MODE_BILIN, 3, 3);
        send_sample(MODE_NEAR, 13, 2);

        for (int ph = 0; ph < 12; ph++) begin
            set_config(rand_coef(2 * 65536), rand_coef(2 * 65536), rand_coef(16 * 65536),
                       rand_coef(2 * 65536), rand_coef(2 * 65536), rand_coef(16 * 65536),
                       rand_size(), rand_size());
            calm = (ph == 11);
            for (int n = 0; n < 45; n++) begin
                sel = $urandom_range(0, 19);
                if (sel < 4)
                    send_request(MODE_LOAD, $urandom_range(0, REGION - 1),
                                 $urandom_range(0, REGION - 1), 24'($urandom));
                else if (sel == 4)
                    send_request(MODE_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                 24'($urandom));
                else if (sel == 5)
                    send_request(MODE_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                 24'($urandom));
                else
                    random_sample();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
